// ===== rtl/ole_pkg.sv =====
// Shared types and constants for the ordered list engine.
package ole_pkg;

    localparam int OLE_CAPACITY = 16;

    typedef enum logic [2:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_INSERT     = 3'd4,
        OP_SEARCH     = 3'd5
    } t_op;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_BADPOS = 2'd3
    } t_status;

    typedef struct packed {
        logic [2:0]         operation;
        logic signed [31:0] value;
        logic [4:0]         position;
    } t_cmd;

    typedef struct packed {
        logic [1:0] status;
        logic       found;
        logic [3:0] found_index;
    } t_res;

    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_INSERT = 2'd1,
        CELL_SHIFT  = 2'd2
    } t_cell_op;

    typedef struct packed {
        t_cell_op op;
        logic     hit_load;
        logic     hit_shift;
    } t_cell_ctl;

endpackage

// ===== rtl/ordered_list_engine.sv =====
// Ordered list engine: a row of slot cells, front at cell 0, with a small sequencer.
// Push, pop, insert: one beat per cycle if idle, result strobed the cycle after start.
// Search: compare occupied cells at accept; match bits then shift toward cell 0 one
// slot per cycle; the result strobes when a hit reaches cell 0 or the last slot misses.
// busy is high while that shift runs. Synchronous active-low reset empties the list.
// Results cannot be held off by the receiver; each o_valid pulse is one beat.
module ordered_list_engine import ole_pkg::*; #(
    parameter int CAPACITY = OLE_CAPACITY
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    input  t_cmd i_cmd,
    output logic busy,
    output logic o_valid,
    output t_res o_res
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int PW    = (CNT_W > 5) ? CNT_W : 5;
    localparam int IW    = (CNT_W > 4) ? CNT_W : 4;
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(CAPACITY);
    localparam logic [CNT_W-1:0] ONE      = CNT_W'(1);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_SCAN = 2'b10
    } t_state;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] r_scan, n_scan;
    logic             r_valid, n_valid;
    t_res             r_res, n_res;

    t_cell_ctl        w_ctl;
    logic [PW-1:0]    w_at;
    logic [PW-1:0]    w_pos_ext, w_cnt_ext;
    logic [IW-1:0]    w_scan_ext;
    logic             w_accept, w_full, w_empty;
    logic [31:0]      w_data [CAPACITY];
    logic             w_hit  [CAPACITY];

    assign busy       = (r_state == S_SCAN);
    assign w_accept   = start && !busy;
    assign w_full     = (r_count == FULL_CNT);
    assign w_empty    = (r_count == '0);
    assign w_pos_ext  = PW'(i_cmd.position);
    assign w_cnt_ext  = PW'(r_count);
    assign w_scan_ext = IW'(r_scan);

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_scan      = r_scan;
        n_valid     = 1'b0;
        n_res       = '0;
        w_ctl.op        = CELL_HOLD;
        w_ctl.hit_load  = 1'b0;
        w_ctl.hit_shift = 1'b0;
        w_at        = '0;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_valid = 1'b1;
                    case (i_cmd.operation)
                        OP_PUSH_FRONT, OP_PUSH_BACK, OP_INSERT: begin
                            if (w_full) begin
                                n_res.status = ST_FULL;
                            end else if (i_cmd.operation == OP_INSERT &&
                                         w_pos_ext > w_cnt_ext) begin
                                n_res.status = ST_BADPOS;
                            end else begin
                                w_ctl.op = CELL_INSERT;
                                if (i_cmd.operation == OP_PUSH_FRONT) begin
                                    w_at = '0;
                                end else if (i_cmd.operation == OP_PUSH_BACK) begin
                                    w_at = w_cnt_ext;
                                end else begin
                                    w_at = w_pos_ext;
                                end
                                n_count = r_count + ONE;
                            end
                        end
                        OP_POP_FRONT: begin
                            if (w_empty) begin
                                n_res.status = ST_EMPTY;
                            end else begin
                                w_ctl.op = CELL_SHIFT;
                                n_count  = r_count - ONE;
                            end
                        end
                        OP_POP_BACK: begin
                            if (w_empty) begin
                                n_res.status = ST_EMPTY;
                            end else begin
                                n_count = r_count - ONE;
                            end
                        end
                        OP_SEARCH: begin
                            // empty list misses at once; otherwise start the shift scan
                            if (!w_empty) begin
                                n_valid        = 1'b0;
                                w_ctl.hit_load = 1'b1;
                                n_scan         = '0;
                                n_state        = S_SCAN;
                            end
                        end
                        default: n_res = '0;
                    endcase
                end
            end
            S_SCAN: begin
                if (w_hit[0]) begin
                    n_valid           = 1'b1;
                    n_res.found       = 1'b1;
                    n_res.found_index = w_scan_ext[3:0];
                    n_state           = S_IDLE;
                end else if (r_scan == r_count - ONE) begin
                    n_valid = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    w_ctl.hit_shift = 1'b1;
                    n_scan          = r_scan + ONE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            logic [31:0] w_left, w_right;
            logic        w_right_hit;
            if (g == 0) begin : g_first
                assign w_left = '0;
            end else begin : g_mid
                assign w_left = w_data[g-1];
            end
            if (g == CAPACITY - 1) begin : g_last
                assign w_right     = '0;
                assign w_right_hit = 1'b0;
            end else begin : g_inner
                assign w_right     = w_data[g+1];
                assign w_right_hit = w_hit[g+1];
            end
            ole_cell #(
                .CAPACITY (CAPACITY),
                .IDX      (g)
            ) u_cell (
                .i_clk        (i_clk),
                .i_ctl        (w_ctl),
                .i_at         (w_at),
                .i_count      (r_count),
                .i_value      (i_cmd.value),
                .i_left_data  (w_left),
                .i_right_data (w_right),
                .i_right_hit  (w_right_hit),
                .o_data       (w_data[g]),
                .o_hit        (w_hit[g])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_scan  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_scan  <= n_scan;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("entry count above capacity");

    a_search_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && i_cmd.operation == OP_SEARCH && !w_empty |=> busy && !o_valid)
        else $error("search on non-empty list did not start a scan");

    a_quick_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && i_cmd.operation != OP_SEARCH |=> o_valid)
        else $error("missing result beat");

    a_found_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_res.found |-> o_res.status == ST_OK && $past(busy))
        else $error("hit reported outside a scan");

endmodule

// ===== rtl/ole_cell.sv =====
// One slot of the list: stored word plus a match bit that shifts toward the front.
module ole_cell import ole_pkg::*; #(
    parameter int CAPACITY = OLE_CAPACITY,
    parameter int IDX      = 0
) (
    input  logic                              i_clk,
    input  t_cell_ctl                         i_ctl,
    input  logic [((($clog2(CAPACITY+1)) > 5) ? $clog2(CAPACITY+1) : 5)-1:0] i_at,
    input  logic [$clog2(CAPACITY+1)-1:0]     i_count,
    input  logic [31:0]                       i_value,
    input  logic [31:0]                       i_left_data,
    input  logic [31:0]                       i_right_data,
    input  logic                              i_right_hit,
    output logic [31:0]                       o_data,
    output logic                              o_hit
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int PW    = (CNT_W > 5) ? CNT_W : 5;
    localparam logic [PW-1:0]    MY_AT  = PW'(IDX);
    localparam logic [CNT_W-1:0] MY_CNT = CNT_W'(IDX);

    logic [31:0] r_data, n_data;
    logic        r_hit, n_hit;

    always_comb begin
        n_data = r_data;
        case (i_ctl.op)
            CELL_INSERT: begin
                if (i_at == MY_AT) begin
                    n_data = i_value;
                end else if (i_at < MY_AT) begin
                    n_data = i_left_data;
                end
            end
            CELL_SHIFT:  n_data = i_right_data;
            default:     n_data = r_data;
        endcase
    end

    always_comb begin
        n_hit = r_hit;
        if (i_ctl.hit_load) begin
            n_hit = (r_data == i_value) && (MY_CNT < i_count);
        end else if (i_ctl.hit_shift) begin
            n_hit = i_right_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
        r_hit  <= n_hit;
    end

    assign o_data = r_data;
    assign o_hit  = r_hit;

endmodule
